@@ src/rcf_pkg.sv @@
`default_nettype none

package rcf_pkg;

    localparam int TABLE_SIZE = 96;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [4:0] CODE_LTRS = 5'h1F;
    localparam logic [4:0] CODE_FIGS = 5'h1B;
    localparam logic [3:0] BAUDOT_BITS = 4'd5;

    localparam logic [2:0] BIT_HALVES = 3'd2;
    localparam logic [2:0] STOP_HALVES_SHORT = 3'd3;
    localparam logic [2:0] STOP_HALVES_LONG = 3'd4;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_ENCODING_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TWO_STOP_BITS = 2'd1;

    typedef enum logic [1:0] {
        CLS_NONE   = 2'd0,
        CLS_LETTER = 2'd1,
        CLS_FIGURE = 2'd2,
        CLS_BOTH   = 2'd3
    } char_class_t;

    typedef enum logic {
        SEQ_FIRST  = 1'b0,
        SEQ_SECOND = 1'b1
    } seq_state_t;

    // one queued character, already classified
    typedef struct packed {
        logic       has_shift;
        logic [4:0] shift_code;
        logic [7:0] data;
        logic [3:0] data_bits;
        logic [2:0] stop_halves;
    } rcf_cmd_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } q_status_t;

    // bits 6..5 class, bits 4..0 ITA2 code
    localparam logic [6:0] ITA2_ROM [TABLE_SIZE] = '{
        7'h60, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h45,
        7'h00, 7'h00, 7'h62, 7'h00, 7'h00, 7'h68, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h64, 7'h4d, 7'h51, 7'h54, 7'h49, 7'h00, 7'h5a, 7'h4b,
        7'h4f, 7'h52, 7'h00, 7'h52, 7'h4c, 7'h43, 7'h5c, 7'h5d,
        7'h56, 7'h57, 7'h53, 7'h41, 7'h4a, 7'h50, 7'h55, 7'h47,
        7'h46, 7'h58, 7'h4e, 7'h5e, 7'h00, 7'h00, 7'h00, 7'h59,
        7'h00, 7'h23, 7'h39, 7'h2e, 7'h29, 7'h21, 7'h2d, 7'h3a,
        7'h34, 7'h26, 7'h2b, 7'h2f, 7'h32, 7'h3c, 7'h2c, 7'h38,
        7'h36, 7'h37, 7'h2a, 7'h25, 7'h30, 7'h27, 7'h3e, 7'h33,
        7'h3d, 7'h35, 7'h31, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

endpackage

`default_nettype wire

@@ src/rcf_front.sv @@
`default_nettype none

module rcf_front #(
    parameter int ASCII_DATA_BITS = 7
) (
    input  wire logic [7:0]      character,
    input  wire logic            encoding_mode,
    input  wire logic            two_stop_bits,
    output rcf_pkg::rcf_cmd_t    cmd
);

    logic [6:0]                 rom_entry;
    rcf_pkg::char_class_t       cls;

    always_comb
    begin
        // codes at 0x60 and above are not encodable
        if (character < 8'(rcf_pkg::TABLE_SIZE))
        begin
            rom_entry = rcf_pkg::ITA2_ROM[character[6:0]];
        end
        else
        begin
            rom_entry = 7'd0;
        end
        cls = rcf_pkg::char_class_t'(rom_entry[6:5]);

        cmd.stop_halves = two_stop_bits ? rcf_pkg::STOP_HALVES_LONG
                                        : rcf_pkg::STOP_HALVES_SHORT;
        cmd.has_shift  = 1'b0;
        cmd.shift_code = rcf_pkg::CODE_LTRS;

        if (!encoding_mode)
        begin
            cmd.data      = character;
            cmd.data_bits = 4'(ASCII_DATA_BITS);
        end
        else
        begin
            cmd.data      = {3'd0, rom_entry[4:0]};
            cmd.data_bits = rcf_pkg::BAUDOT_BITS;
            case (cls)
                rcf_pkg::CLS_LETTER:
                begin
                    cmd.has_shift  = 1'b1;
                    cmd.shift_code = rcf_pkg::CODE_LTRS;
                end
                rcf_pkg::CLS_FIGURE:
                begin
                    cmd.has_shift  = 1'b1;
                    cmd.shift_code = rcf_pkg::CODE_FIGS;
                end
                default:
                begin
                    cmd.has_shift = 1'b0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ src/rcf_queue.sv @@
`default_nettype none

module rcf_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire rcf_pkg::rcf_cmd_t  push_cmd,
    input  wire logic               pop,
    output rcf_pkg::rcf_cmd_t       head_cmd,
    output rcf_pkg::q_status_t      status
);

    localparam int PTR_W = $clog2(rcf_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(rcf_pkg::QUEUE_DEPTH + 1);

    rcf_pkg::rcf_cmd_t  mem [rcf_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(rcf_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(rcf_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head_cmd         = mem[rd_ptr_reg];
    assign status.full      = (count_reg == CNT_W'(rcf_pkg::QUEUE_DEPTH));
    assign status.not_empty = (count_reg != '0);

endmodule

`default_nettype wire

@@ src/rcf_back.sv @@
`default_nettype none

module rcf_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    input  wire rcf_pkg::rcf_cmd_t  cmd,
    output logic                    cmd_pop,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    line_level,
    output logic [2:0]              half_bit_count,
    output logic                    last_element
);

    rcf_pkg::seq_state_t state_reg, state_next;
    logic [3:0]  idx_reg, idx_next;
    logic        out_valid_reg;
    logic        level_reg, level_next;
    logic [2:0]  halves_reg, halves_next;
    logic        last_reg, last_next;

    logic        advance;
    logic        in_shift;
    logic [7:0]  frame_data;
    logic [3:0]  frame_bits;
    logic        at_stop;
    logic [2:0]  bit_sel;

    // element index: 0 start, 1..frame_bits data, frame_bits+1 stop
    always_comb
    begin
        advance    = cmd_valid && (!out_valid_reg || !out_stall);
        in_shift   = (state_reg == rcf_pkg::SEQ_FIRST) && cmd.has_shift;
        frame_data = in_shift ? {3'd0, cmd.shift_code} : cmd.data;
        frame_bits = in_shift ? rcf_pkg::BAUDOT_BITS : cmd.data_bits;
        at_stop    = (idx_reg == frame_bits + 4'd1);
        bit_sel    = 3'(idx_reg - 4'd1);

        state_next  = state_reg;
        idx_next    = idx_reg;
        cmd_pop     = 1'b0;
        level_next  = level_reg;
        halves_next = halves_reg;
        last_next   = last_reg;

        if (advance)
        begin
            last_next = at_stop && !in_shift;
            if (idx_reg == 4'd0)
            begin
                level_next  = 1'b0;
                halves_next = rcf_pkg::BIT_HALVES;
            end
            else if (at_stop)
            begin
                level_next  = 1'b1;
                halves_next = cmd.stop_halves;
            end
            else
            begin
                level_next  = frame_data[bit_sel];
                halves_next = rcf_pkg::BIT_HALVES;
            end

            if (at_stop)
            begin
                idx_next = 4'd0;
                case (state_reg)
                    rcf_pkg::SEQ_FIRST:
                    begin
                        if (in_shift)
                        begin
                            state_next = rcf_pkg::SEQ_SECOND;
                        end
                        else
                        begin
                            cmd_pop = 1'b1;
                        end
                    end
                    default:
                    begin
                        state_next = rcf_pkg::SEQ_FIRST;
                        cmd_pop    = 1'b1;
                    end
                endcase
            end
            else
            begin
                idx_next = idx_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rcf_pkg::SEQ_FIRST;
            idx_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (!out_valid_reg || !out_stall)
            begin
                out_valid_reg <= cmd_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        level_reg  <= level_next;
        halves_reg <= halves_next;
        last_reg   <= last_next;
    end

    assign out_valid      = out_valid_reg;
    assign line_level     = level_reg;
    assign half_bit_count = halves_reg;
    assign last_element   = last_reg;

endmodule

`default_nettype wire

@@ src/rtty_character_framer_unit.sv @@
// RTTY character framer: one character in, a train of line elements out.
// Input channel: in_valid / in_stall with the 8-bit character. A beat is
// taken when in_valid is high and in_stall low.
// Output channel: out_valid / out_stall with line_level (1 mark, 0 space),
// half_bit_count (2 for start/data, 3 or 4 for the stop element) and
// last_element, set on the final element of a character.
// Config: cfg_valid / cfg_ready with cfg_index and cfg_data; index 0 is
// encoding_mode (0 ASCII, 1 Baudot ITA2), index 1 two_stop_bits. Other
// indexes are ignored. cfg_ready is always high; write only while idle.
// The queue and the output register lie between a beat and its first
// element. The back end emits one element per cycle while out_stall is
// low and the queue is not empty: 9 elements for an ASCII character
// (ASCII_DATA_BITS + 2), 7 for Baudot, 14 when a LTRS/FIGS frame leads it.
// The sequencer sets these; a two-entry queue takes the next characters.
// A stalled receiver holds the output register; the sequencer waits and the
// queue fills, then in_stall rises.
// Reset clears the queue and sequencer and loads ASCII mode, 2-bit stop.
`default_nettype none

module rtty_character_framer_unit #(
    parameter int ASCII_DATA_BITS = 7
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [7:0]                      character,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic                                 line_level,
    output logic [2:0]                           half_bit_count,
    output logic                                 last_element,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [rcf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic                            cfg_data
);

    logic                   encoding_mode_reg;
    logic                   two_stop_bits_reg;
    rcf_pkg::rcf_cmd_t      front_cmd;
    rcf_pkg::rcf_cmd_t      head_cmd;
    rcf_pkg::q_status_t     q_status;
    logic                   push;
    logic                   pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            encoding_mode_reg <= 1'b0;
            two_stop_bits_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rcf_pkg::REG_ENCODING_MODE: encoding_mode_reg <= cfg_data;
                rcf_pkg::REG_TWO_STOP_BITS: two_stop_bits_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign in_stall = q_status.full;
    assign push     = in_valid && !in_stall;

    rcf_front #(
        .ASCII_DATA_BITS(ASCII_DATA_BITS)
    ) u_front (
        .character     (character),
        .encoding_mode (encoding_mode_reg),
        .two_stop_bits (two_stop_bits_reg),
        .cmd           (front_cmd)
    );

    rcf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (front_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    rcf_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (q_status.not_empty),
        .cmd            (head_cmd),
        .cmd_pop        (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .line_level     (line_level),
        .half_bit_count (half_bit_count),
        .last_element   (last_element)
    );

    // the final element of a character is always its stop element
    a_last_is_stop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_element |-> line_level
            && (half_bit_count == rcf_pkg::STOP_HALVES_SHORT
                || half_bit_count == rcf_pkg::STOP_HALVES_LONG))
        else $error("last element is not a stop element");

    // space is only ever a start or data bit
    a_space_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !line_level |-> half_bit_count == rcf_pkg::BIT_HALVES)
        else $error("space element with wrong length");

    // the sequencer never pops an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_status.not_empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    localparam int ASCII_BITS = 7;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 24;
    localparam int DRAIN_CYCLES = 32;
    localparam int MAX_REPORTS = 10;

    // indexes beyond the register list, writes must be dropped
    localparam logic [rcf_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [rcf_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

    // class in bits 6..5, ITA2 code in bits 4..0
    localparam logic [6:0] ITA2_TABLE [rcf_pkg::TABLE_SIZE] = '{
        7'h60, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h45,
        7'h00, 7'h00, 7'h62, 7'h00, 7'h00, 7'h68, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h64, 7'h4d, 7'h51, 7'h54, 7'h49, 7'h00, 7'h5a, 7'h4b,
        7'h4f, 7'h52, 7'h00, 7'h52, 7'h4c, 7'h43, 7'h5c, 7'h5d,
        7'h56, 7'h57, 7'h53, 7'h41, 7'h4a, 7'h50, 7'h55, 7'h47,
        7'h46, 7'h58, 7'h4e, 7'h5e, 7'h00, 7'h00, 7'h00, 7'h59,
        7'h00, 7'h23, 7'h39, 7'h2e, 7'h29, 7'h21, 7'h2d, 7'h3a,
        7'h34, 7'h26, 7'h2b, 7'h2f, 7'h32, 7'h3c, 7'h2c, 7'h38,
        7'h36, 7'h37, 7'h2a, 7'h25, 7'h30, 7'h27, 7'h3e, 7'h33,
        7'h3d, 7'h35, 7'h31, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    typedef struct packed {
        logic       level;
        logic [2:0] halves;
        logic       last;
    } line_element_t;

    typedef enum logic [1:0] {
        ROW_CHAR = 2'd0,
        ROW_CFG  = 2'd1
    } row_kind_t;

    // typed rows carry the shift class and code read straight off the spec
    typedef struct packed {
        row_kind_t                        kind;
        logic [rcf_pkg::CFG_INDEX_W-1:0]  idx;
        logic                             value;
        logic [7:0]                       ch;
        logic                             typed;
        rcf_pkg::char_class_t             t_cls;
        logic [7:0]                       t_code;
    } stim_row_t;

    localparam int DIRECTED_COUNT = 28;
    localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{ROW_CHAR, rcf_pkg::REG_ENCODING_MODE, 1'b0, 8'h00, 1'b1, rcf_pkg::CLS_NONE, 8'h00},
        '{ROW_CHAR, rcf_pkg::REG_ENCODING_MODE, 1'b0, 8'hFF, 1'b1, rcf_pkg::CLS_NONE, 8'h7F},
        '{ROW_CHAR, rcf_pkg::REG_ENCODING_MODE, 1'b0, 8'h80, 1'b1, rcf_pkg::CLS_NONE, 8'h00},
        '{ROW_CHAR, rcf_pkg::REG_ENCODING_MODE, 1'b0, 8'h55, 1'b0, rcf_pkg::CLS_NONE, 8'h00},
        '{ROW_CFG,  rcf_pkg::REG_TWO_STOP_BITS, 1'b0, 8'h00, 1'b0, rcf_pkg::CLS_NONE, 8'h00},
        '{ROW_CHAR, rcf_pkg::REG_ENCODING_MODE, 1'b0, 8'h7F, 1'b1, rcf_pkg::CLS_NONE, 8'h7F},
        '{ROW_CHAR, rcf_pkg::REG_ENCODING_MODE, 1'b0, 8'h2A, 1'b0, rcf_pkg::CLS_NONE, 8'h00},
        '{ROW_CFG,  rcf_pkg::REG_ENCODING_MODE, 1'b1, 8'h00, 1'b0, rcf_pkg::CLS_NONE, 8'h00},
        '{ROW_CHAR, rcf_pkg::REG_ENCODING_MODE, 1'b0, 8'h41, 1'b0, rcf_pkg::CLS_NONE, 8'h00},
        '{ROW_CHAR, rcf_pkg::REG_ENCODING_MODE, 1'b0, 8'h31, 1'b0, rcf_pkg::CLS_NONE, 8'h00},
        '{ROW_CHAR, rcf_pkg::REG_ENCODING_MODE, 1'b0, 8'h00, 1'b1, rcf_pkg::CLS_NONE, 8'h00},
        '{ROW_CHAR, rcf_pkg::REG_ENCODING_MODE, 1'b0, 8'h0A, 1'b0, rcf_pkg::CLS_NONE, 8'h00},
        '{ROW_CHAR, rcf_pkg::REG_ENCODING_MODE, 1'b0, 8'h0D, 1'b0, rcf_pkg::CLS_NONE, 8'h00},
        '{ROW_CHAR, rcf_pkg::REG_ENCODING_MODE, 1'b0, 8'h20, 1'b0, rcf_pkg::CLS_NONE, 8'h00},
        '{ROW_CHAR, rcf_pkg::REG_ENCODING_MODE, 1'b0, 8'h25, 1'b1, rcf_pkg::CLS_NONE, 8'h00},
        '{ROW_CHAR, rcf_pkg::REG_ENCODING_MODE, 1'b0, 8'h60, 1'b1, rcf_pkg::CLS_NONE, 8'h00},
        '{ROW_CHAR, rcf_pkg::REG_ENCODING_MODE, 1'b0, 8'hFF, 1'b1, rcf_pkg::CLS_NONE, 8'h00},
        '{ROW_CHAR, rcf_pkg::REG_ENCODING_MODE, 1'b0, 8'h5F, 1'b1, rcf_pkg::CLS_NONE, 8'h00},
        '{ROW_CFG,  rcf_pkg::REG_TWO_STOP_BITS, 1'b1, 8'h00, 1'b0, rcf_pkg::CLS_NONE, 8'h00},
        '{ROW_CHAR, rcf_pkg::REG_ENCODING_MODE, 1'b0, 8'h5A, 1'b0, rcf_pkg::CLS_NONE, 8'h00},
        '{ROW_CHAR, rcf_pkg::REG_ENCODING_MODE, 1'b0, 8'h3F, 1'b0, rcf_pkg::CLS_NONE, 8'h00},
        '{ROW_CHAR, rcf_pkg::REG_ENCODING_MODE, 1'b0, 8'h07, 1'b0, rcf_pkg::CLS_NONE, 8'h00},
        '{ROW_CFG,  REG_SPARE_LO,               1'b0, 8'h00, 1'b0, rcf_pkg::CLS_NONE, 8'h00},
        '{ROW_CFG,  REG_SPARE_HI,               1'b0, 8'h00, 1'b0, rcf_pkg::CLS_NONE, 8'h00},
        '{ROW_CHAR, rcf_pkg::REG_ENCODING_MODE, 1'b0, 8'h45, 1'b0, rcf_pkg::CLS_NONE, 8'h00},
        '{ROW_CFG,  rcf_pkg::REG_ENCODING_MODE, 1'b0, 8'h00, 1'b0, rcf_pkg::CLS_NONE, 8'h00},
        '{ROW_CHAR, rcf_pkg::REG_ENCODING_MODE, 1'b0, 8'hC1, 1'b0, rcf_pkg::CLS_NONE, 8'h00},
        '{ROW_CHAR, rcf_pkg::REG_ENCODING_MODE, 1'b0, 8'h01, 1'b0, rcf_pkg::CLS_NONE, 8'h00}
    };

    logic                            clk;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    logic [7:0]                      character = 8'h00;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic                            line_level;
    logic [2:0]                      half_bit_count;
    logic                            last_element;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [rcf_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic                            cfg_data = 1'b0;

    // shadow of the block's registers, reset values
    logic model_baudot = 1'b0;
    logic model_two_stop = 1'b1;

    line_element_t expected_elements [$];
    int  mismatches = 0;
    int  out_hold = 0;
    bit  in_idle = 1'b1;
    bit  out_idle = 1'b1;

    rtty_character_framer_unit #(
        .ASCII_DATA_BITS(ASCII_BITS)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .character     (character),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .line_level    (line_level),
        .half_bit_count(half_bit_count),
        .last_element  (last_element),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // start bit, data bits LSB first, stop element
    function automatic void push_frame(input logic [7:0] data, input int nbits,
                                       input logic final_frame);
        line_element_t e;
        e.level = 1'b0;
        e.halves = rcf_pkg::BIT_HALVES;
        e.last = 1'b0;
        expected_elements.push_back(e);
        for (int b = 0; b < nbits; b++)
        begin
            e.level = data[b];
            expected_elements.push_back(e);
        end
        e.level = 1'b1;
        e.halves = model_two_stop ? rcf_pkg::STOP_HALVES_LONG : rcf_pkg::STOP_HALVES_SHORT;
        e.last = final_frame;
        expected_elements.push_back(e);
    endfunction

    function automatic void frame_character(input logic [7:0] ch, input logic typed,
                                            input rcf_pkg::char_class_t t_cls,
                                            input logic [7:0] t_code);
        logic [6:0]           entry;
        rcf_pkg::char_class_t cls;
        logic [7:0]           code;
        if (!model_baudot)
        begin
            push_frame(typed ? t_code : ch, ASCII_BITS, 1'b1);
        end
        else
        begin
            entry = (ch < rcf_pkg::TABLE_SIZE) ? ITA2_TABLE[ch[6:0]] : 7'h00;
            cls = typed ? t_cls : rcf_pkg::char_class_t'(entry[6:5]);
            code = typed ? t_code : {3'b000, entry[4:0]};
            if (cls == rcf_pkg::CLS_LETTER)
                push_frame({3'b000, rcf_pkg::CODE_LTRS}, rcf_pkg::BAUDOT_BITS, 1'b0);
            else if (cls == rcf_pkg::CLS_FIGURE)
                push_frame({3'b000, rcf_pkg::CODE_FIGS}, rcf_pkg::BAUDOT_BITS, 1'b0);
            push_frame(code, rcf_pkg::BAUDOT_BITS, 1'b1);
        end
    endfunction

    task automatic send_char(input logic [7:0] ch, input logic typed,
                             input rcf_pkg::char_class_t t_cls, input logic [7:0] t_code);
        int gap;
        gap = in_idle ? $urandom_range(0, 15) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        character <= ch;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        frame_character(ch, typed, t_cls, t_code);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_elements.size() != 0) @(posedge clk);
    endtask

    // leaves cfg_valid high; caller drops it after the last write
    task automatic write_register(input logic [rcf_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == rcf_pkg::REG_ENCODING_MODE)
            model_baudot = val;
        else if (idx == rcf_pkg::REG_TWO_STOP_BITS)
            model_two_stop = val;
    endtask

    always @(posedge clk)
    begin : element_check
        line_element_t got;
        line_element_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got.level = line_level;
            got.halves = half_bit_count;
            got.last = last_element;
            if (expected_elements.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected element: level=%0b halves=%0d last=%0b",
                             got.level, got.halves, got.last);
            end
            else
            begin
                want = expected_elements.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("element mismatch: exp level=%0b halves=%0d last=%0b,",
                                 want.level, want.halves, want.last,
                                 " got level=%0b halves=%0d last=%0b",
                                 got.level, got.halves, got.last);
                end
            end
            out_hold = out_idle ? $urandom_range(0, 15) : 0;
        end
        out_stall <= (out_hold != 0);
        if (out_hold != 0)
            out_hold--;
    end

    initial
    begin
        logic [7:0] ch;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < DIRECTED_COUNT; r++)
        begin
            if (DIRECTED_ROWS[r].kind == ROW_CFG)
            begin
                if (r == 0 || DIRECTED_ROWS[r-1].kind == ROW_CHAR)
                    wait_idle();
                write_register(DIRECTED_ROWS[r].idx, DIRECTED_ROWS[r].value);
                if (r == DIRECTED_COUNT - 1 || DIRECTED_ROWS[r+1].kind != ROW_CFG)
                    cfg_valid <= 1'b0;
            end
            else
            begin
                send_char(DIRECTED_ROWS[r].ch, DIRECTED_ROWS[r].typed,
                          DIRECTED_ROWS[r].t_cls, DIRECTED_ROWS[r].t_code);
            end
        end

        // every mode/stop combination twice, idling on and off per side
        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            write_register(rcf_pkg::REG_ENCODING_MODE, p[0]);
            write_register(rcf_pkg::REG_TWO_STOP_BITS, p[1]);
            cfg_valid <= 1'b0;
            in_idle = (p % 3 != 2);
            out_idle = (p % 3 != 1);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // mostly table characters, the rest anything
                if ($urandom_range(0, 9) < 7)
                    ch = 8'($urandom_range(0, rcf_pkg::TABLE_SIZE - 1));
                else
                    ch = 8'($urandom_range(0, 255));
                send_char(ch, 1'b0, rcf_pkg::CLS_NONE, 8'h00);
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_elements.size() == 0)
            $display("[rtty_character_framer_unit] OK");
        else
            $display("[rtty_character_framer_unit] ERROR");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("[rtty_character_framer_unit] ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
src/rcf_pkg.sv
src/rcf_front.sv
src/rcf_queue.sv
src/rcf_back.sv
src/rtty_character_framer_unit.sv
tb/tb_top.sv
